>>> sv/spd_pkg.sv
// Shared types and constants for the six-axis serial packet decoder.
// No dependencies; used by spd_ctrl, spd_dp and the top level.
`default_nettype none

package spd_pkg;

  localparam int AXES_DEF        = 6;
  localparam int KEY_NIBBLES_DEF = 3;
  localparam int AXES_MAX        = 6;
  localparam int NIB_SLOTS       = 24;
  localparam int BTN_BITS        = 12;
  localparam int POS_W           = 5;
  localparam int IDX_W           = 4;
  localparam int AXIS_W          = 16;
  localparam int OUT_DATA_W      = 120;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] TAG_MOTION = 8'h64;  // 'd'
  localparam logic [7:0] TAG_KEY    = 8'h6b;  // 'k'

  localparam logic [POS_W-1:0]  POS_EMPTY   = 5'd0;
  localparam logic [AXIS_W-1:0] AXIS_OFFSET = 16'h8000;

  localparam logic KIND_MOTION = 1'b0;
  localparam logic KIND_BUTTON = 1'b1;

  typedef struct packed {
    logic store_byte;   // non-CR byte: tag or nibble
    logic key_start;    // CR on a key line: latch new state and change mask
    logic line_clear;   // drop tag, position and nibbles
    logic load_motion;  // fill output register with a motion result
    logic load_key;     // fill output register with the lowest pending button change
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_cr;
    logic tag_motion;
    logic tag_key;
    logic rem_zero;     // no button changes left
    logic rem_last;     // exactly one button change left
  } dp_stat_t;

endpackage

`default_nettype wire

>>> sv/spd_ctrl.sv
// Controller for the six-axis serial packet decoder: sequences line ends
// and result emission. Depends on spd_pkg.
`default_nettype none

module spd_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire                 out_tready,
  input  spd_pkg::dp_stat_t   stat,
  output spd_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOTION,
    S_KEYS
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   in_acc;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority if (!stat.is_cr) begin
            cmd.store_byte = 1'b1;
          end else if (stat.tag_motion) begin
            state_nxt = S_MOTION;
          end else if (stat.tag_key) begin
            cmd.key_start  = 1'b1;
            cmd.line_clear = 1'b1;
            state_nxt      = S_KEYS;
          end else begin
            cmd.line_clear = 1'b1;
          end
        end
      end
      S_MOTION: begin
        if (slot_free) begin
          cmd.load_motion = 1'b1;
          cmd.line_clear  = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_KEYS: begin
        priority if (stat.rem_zero) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          cmd.load_key  = 1'b1;
          out_valid_nxt = 1'b1;
          if (stat.rem_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/spd_dp.sv
// Datapath for the six-axis serial packet decoder: line buffer, button
// state, change scan and the output register. Depends on spd_pkg.
`default_nettype none

module spd_dp #(
  parameter int AXES        = spd_pkg::AXES_DEF,
  parameter int KEY_NIBBLES = spd_pkg::KEY_NIBBLES_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire  [7:0]                    rx_byte,
  input  spd_pkg::ctrl_cmd_t            cmd,
  output spd_pkg::dp_stat_t             stat,
  output logic                          event_kind,
  output logic [spd_pkg::AXIS_W-1:0]    axis_out [spd_pkg::AXES_MAX],
  output logic [spd_pkg::IDX_W-1:0]     button_index,
  output logic                          button_down,
  output logic [spd_pkg::BTN_BITS-1:0]  buttons_before_toggle,
  output logic                          last
);

  // only the nibbles that some result reads are stored
  localparam int NIB_DEPTH = (AXES * 4 > KEY_NIBBLES) ? AXES * 4 : KEY_NIBBLES;
  localparam int POS_W     = spd_pkg::POS_W;
  localparam int BTN_BITS  = spd_pkg::BTN_BITS;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(spd_pkg::NIB_SLOTS);

  logic [POS_W-1:0]    pos_r;
  logic [7:0]          tag_r;
  logic [3:0]          nib_r [NIB_DEPTH];
  logic [BTN_BITS-1:0] held_r, prev_r, st_r, rem_r;

  logic [spd_pkg::NIB_SLOTS*4-1:0] nib_flat;
  logic [31:0]                     key_word;
  logic [BTN_BITS-1:0]             key_state;
  logic [BTN_BITS-1:0]             low_onehot;
  logic [spd_pkg::IDX_W-1:0]       low_idx;
  logic [POS_W-1:0]                wr_slot;
  logic                            line_open;

  assign line_open = (pos_r != spd_pkg::POS_EMPTY);
  assign wr_slot   = pos_r - POS_W'(1);

  always_comb begin
    nib_flat = '0;
    for (int k = 0; k < NIB_DEPTH; k++) begin
      nib_flat[4*k +: 4] = nib_r[k];
    end
  end

  always_comb begin
    key_word = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < KEY_NIBBLES) begin
        key_word[4*i +: 4] = nib_flat[4*i +: 4];
      end
    end
  end
  assign key_state = key_word[BTN_BITS-1:0];

  // lowest pending change bit
  assign low_onehot = rem_r & (~rem_r + BTN_BITS'(1));
  always_comb begin
    low_idx = '0;
    for (int i = BTN_BITS - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        low_idx = spd_pkg::IDX_W'(i);
      end
    end
  end

  assign stat.is_cr      = (rx_byte == spd_pkg::CHAR_CR);
  assign stat.tag_motion = line_open && (tag_r == spd_pkg::TAG_MOTION);
  assign stat.tag_key    = line_open && (tag_r == spd_pkg::TAG_KEY);
  assign stat.rem_zero   = (rem_r == '0);
  assign stat.rem_last   = !stat.rem_zero && ((rem_r & ~low_onehot) == '0);

  // line buffer
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.line_clear) begin
      pos_r <= spd_pkg::POS_EMPTY;
      tag_r <= '0;
      for (int k = 0; k < NIB_DEPTH; k++) begin
        nib_r[k] <= '0;
      end
    end else if (cmd.store_byte) begin
      if (!line_open) begin
        tag_r <= rx_byte;
        pos_r <= POS_W'(1);
      end else if (pos_r <= POS_LIMIT) begin
        for (int k = 0; k < NIB_DEPTH; k++) begin
          if (wr_slot == POS_W'(k)) begin
            nib_r[k] <= rx_byte[3:0];
          end
        end
        pos_r <= pos_r + POS_W'(1);
      end
    end
  end

  // button state and change scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      rem_r  <= '0;
    end else if (cmd.key_start) begin
      held_r <= key_state;
      rem_r  <= key_state ^ held_r;
    end else if (cmd.load_key) begin
      rem_r <= rem_r & ~low_onehot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_start) begin
      prev_r <= held_r;
      st_r   <= key_state;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_motion) begin
      event_kind            <= spd_pkg::KIND_MOTION;
      button_index          <= '0;
      button_down           <= 1'b0;
      buttons_before_toggle <= '0;
      last                  <= 1'b1;
      for (int a = 0; a < spd_pkg::AXES_MAX; a++) begin
        if (a < AXES) begin
          // four nibbles, most significant first, minus 32768
          axis_out[a] <= nib_flat[16*a +: 16] == 16'h0 ? spd_pkg::AXIS_OFFSET :
                         {nib_flat[16*a +: 4], nib_flat[16*a+4 +: 4],
                          nib_flat[16*a+8 +: 4], nib_flat[16*a+12 +: 4]}
                         ^ spd_pkg::AXIS_OFFSET;
        end else begin
          axis_out[a] <= '0;
        end
      end
    end else if (cmd.load_key) begin
      event_kind            <= spd_pkg::KIND_BUTTON;
      button_index          <= low_idx;
      button_down           <= ((st_r & low_onehot) != '0);
      buttons_before_toggle <= prev_r ^ low_onehot;
      last                  <= stat.rem_last;
      for (int a = 0; a < spd_pkg::AXES_MAX; a++) begin
        axis_out[a] <= '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/six_axis_serial_packet_decoder.sv
// Six-axis serial packet decoder top level: byte stream in, motion and button events out.
// A carriage return on a motion or key line enters S_MOTION or S_KEYS, where each result
// waits for a free output register. Throughput: one byte per cycle while a line fills;
// a motion or key line end holds the input until its results are out, set by the single
// output register and the one-change-per-cycle scan, which waits on a full output.
// Reset (rst_n low, synchronous) empties the line buffer, button state and output.
`default_nettype none

module six_axis_serial_packet_decoder #(
  parameter int AXES        = spd_pkg::AXES_DEF,
  parameter int KEY_NIBBLES = spd_pkg::KEY_NIBBLES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  // [15:0] trans_x, [31:16] trans_y, [47:32] trans_z, [63:48] rot_x, [79:64] rot_y,
  // [95:80] rot_z, [99:96] button_index, [100] button_down,
  // [112:101] buttons_before_toggle, [119:113] zero
  output logic [spd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [0:0]  out_tuser,  // [0] event_kind
  output logic        out_tlast   // last
);

  spd_pkg::ctrl_cmd_t cmd;
  spd_pkg::dp_stat_t  stat;

  logic                         event_kind;
  logic [spd_pkg::AXIS_W-1:0]   axis_out [spd_pkg::AXES_MAX];
  logic [spd_pkg::IDX_W-1:0]    button_index;
  logic                         button_down;
  logic [spd_pkg::BTN_BITS-1:0] buttons_before_toggle;
  logic                         last;

  spd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  spd_dp #(
    .AXES        (AXES),
    .KEY_NIBBLES (KEY_NIBBLES)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .rx_byte               (in_tdata),
    .cmd                   (cmd),
    .stat                  (stat),
    .event_kind            (event_kind),
    .axis_out              (axis_out),
    .button_index          (button_index),
    .button_down           (button_down),
    .buttons_before_toggle (buttons_before_toggle),
    .last                  (last)
  );

  assign out_tdata = {7'd0, buttons_before_toggle, button_down, button_index,
                      axis_out[5], axis_out[4], axis_out[3],
                      axis_out[2], axis_out[1], axis_out[0]};
  assign out_tuser = event_kind;
  assign out_tlast = last;

  // input is only taken once every pending button change has gone out
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> stat.rem_zero)
    else $error("input ready with button changes pending");

  a_motion_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] == spd_pkg::KIND_MOTION) |-> out_tlast)
    else $error("motion result not marked last");

  a_button_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] == spd_pkg::KIND_BUTTON) |->
      (button_index < spd_pkg::IDX_W'(spd_pkg::BTN_BITS)) &&
      (button_down == buttons_before_toggle[button_index]))
    else $error("button result inconsistent");

  a_load_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_key && cmd.load_motion) && !(cmd.store_byte && cmd.line_clear))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire
